[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[hdl/ira_pkg.sv]
// ----------------------------------------------------------------------------
// ira_pkg
// types and constants of the IRA LDPC parity encoder
// ----------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

  localparam int ACC_BITS = 32;
  localparam int CNT_W    = 6;
  localparam int IDX_W    = 8;
  localparam int PIDX_W   = 5;

  localparam logic [CNT_W-1:0] PARITY_RESET = 6'd32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_INFO = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [IDX_W-1:0]    info_index;
    logic [ACC_BITS-1:0] check_mask;
    logic                info_bit;
    logic                frame_last;
  } req_item_t;

  typedef struct packed {
    logic              code_bit;
    logic              is_parity;
    logic [PIDX_W-1:0] parity_index;
    logic              run_last;
  } res_item_t;

  // systematic result offered to the output serializer
  typedef struct packed {
    logic                valid;
    logic                code_bit;
    logic                start_par;
    logic [ACC_BITS-1:0] par_word;
    logic [PIDX_W-1:0]   last_idx;
  } sys_req_t;

endpackage

`default_nettype wire

[hdl/ira_ram.sv]
// ----------------------------------------------------------------------------
// ira_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/ira_par_ser.sv]
// ----------------------------------------------------------------------------
// ira_par_ser
// output register and parity serializer: emits the systematic echo, then the
// accumulator chain of a finished frame one parity bit per transaction
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ira_par_ser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ira_pkg::sys_req_t  sys,
  output logic                    take,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output ira_pkg::res_item_t      res
);
  import ira_pkg::*;

  logic                par_busy;
  logic [ACC_BITS-1:0] par_word;
  logic                par_chain;
  logic [PIDX_W-1:0]   par_idx;
  logic [PIDX_W-1:0]   par_last_idx;
  logic                par_bit_next;
  logic                par_done;
  logic                load;

  assign load         = !res_valid || res_ready;
  assign take         = sys.valid && load && !par_busy;
  assign par_bit_next = par_chain ^ par_word[0];
  assign par_done     = (par_idx == par_last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      par_busy  <= 1'b0;
    end else if (load) begin
      if (par_busy) begin
        res_valid        <= 1'b1;
        res.code_bit     <= par_bit_next;
        res.is_parity    <= 1'b1;
        res.parity_index <= par_idx;
        res.run_last     <= par_done;
        par_chain        <= par_bit_next;
        par_word         <= par_word >> 1;
        par_idx          <= par_idx + PIDX_W'(1);
        if (par_done) begin
          par_busy <= 1'b0;
        end
      end else if (sys.valid) begin
        res_valid        <= 1'b1;
        res.code_bit     <= sys.code_bit;
        res.is_parity    <= 1'b0;
        res.parity_index <= '0;
        res.run_last     <= !sys.start_par;
        if (sys.start_par) begin
          par_busy     <= 1'b1;
          par_word     <= sys.par_word;
          par_chain    <= 1'b0;
          par_idx      <= '0;
          par_last_idx <= sys.last_idx;
        end
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_idx_range, par_busy && (par_idx > par_last_idx), "parity index past end")
  `ASSERT_CLK(a_par_first,
    res_valid && res_ready && !res.is_parity && !res.run_last |=>
      res_valid && res.is_parity && (res.parity_index == '0),
    "parity run does not follow systematic echo")
  `ASSERT_CLK(a_par_step,
    res_valid && res_ready && res.is_parity && !res.run_last |=>
      res_valid && res.is_parity &&
      (res.parity_index == PIDX_W'($past(res.parity_index) + PIDX_W'(1))),
    "parity index not consecutive")

endmodule

`default_nettype wire

[hdl/ira_ldpc_parity_encoder.sv]
// ----------------------------------------------------------------------------
// ira_ldpc_parity_encoder
// systematic IRA LDPC encoder with table-driven check accumulation
// ----------------------------------------------------------------------------
// Load transactions write one check mask per information-bit position into
// the table memory and give no result. Each information bit is read from the
// table, then echoed through the output register and, when set, XORs its
// mask into the check accumulator. One information bit enters per cycle while
// res_ready is high and no parity run is busy; the output register moves one
// result per cycle while res_ready is high, so the last bit of a frame is
// followed by its parity results (parity_count capped at PARITY_MAX and 32),
// during which the request channel stalls. The table memory is not cleared
// after reset: an entry must be loaded before an information bit reads it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ira_ldpc_parity_encoder #(
  parameter int INFO_MAX   = 256,
  parameter int PARITY_MAX = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire ira_pkg::req_item_t            req,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output ira_pkg::res_item_t                 res,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ira_pkg::CNT_W-1:0]     cfg_data
);
  import ira_pkg::*;

  localparam int ADDR_W  = (INFO_MAX > 1) ? $clog2(INFO_MAX) : 1;
  localparam int PAR_LIM = (PARITY_MAX < ACC_BITS) ? PARITY_MAX : ACC_BITS;
  localparam bit ALL_IDX = (INFO_MAX >= (1 << IDX_W));

  logic [CNT_W-1:0]    parity_count;
  logic [CNT_W-1:0]    n_active;
  logic [ACC_BITS-1:0] check_accum;
  logic [ACC_BITS-1:0] accum_next;
  logic [ACC_BITS-1:0] rdata;
  logic                s1_valid;
  logic                s1_bit;
  logic                s1_last;
  logic                s1_ok;
  logic                idx_ok;
  logic                acc_req;
  logic                take;
  sys_req_t            sys;

  assign cfg_ready = 1'b1;
  assign idx_ok    = ALL_IDX || (32'(req.info_index) < INFO_MAX);
  assign acc_req   = req_valid && req_ready;
  assign req_ready = !s1_valid || take;

  ira_ram #(
    .WIDTH(ACC_BITS),
    .DEPTH(INFO_MAX)
  ) u_table (
    .clk  (clk),
    .we   (acc_req && (req.req_type == REQ_LOAD) && idx_ok),
    .waddr(ADDR_W'(req.info_index)),
    .wdata(req.check_mask),
    .re   (acc_req && (req.req_type == REQ_INFO)),
    .raddr(ADDR_W'(req.info_index)),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_count <= PARITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      parity_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid && (req.req_type == REQ_INFO);
    end
    if (req_ready) begin
      s1_bit  <= req.info_bit;
      s1_last <= req.frame_last;
      s1_ok   <= idx_ok;
    end
  end

  always_comb begin
    n_active   = (parity_count > CNT_W'(PAR_LIM)) ? CNT_W'(PAR_LIM) : parity_count;
    accum_next = check_accum ^ ((s1_bit && s1_ok) ? rdata : '0);
    sys.valid     = s1_valid;
    sys.code_bit  = s1_bit;
    sys.start_par = s1_last && (n_active != '0);
    sys.par_word  = accum_next;
    sys.last_idx  = PIDX_W'(n_active - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_accum <= '0;
    end else if (take) begin
      check_accum <= s1_last ? '0 : accum_next;
    end
  end

  ira_par_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .sys      (sys),
    .take     (take),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  `ASSERT_CLK(a_info_to_s1,
    req_valid && req_ready && (req.req_type == REQ_INFO) |=> s1_valid,
    "information transaction lost before table read")
  `ASSERT_CLK(a_s1_hold,
    s1_valid && !take |=> s1_valid && $stable(s1_bit) && $stable(s1_last) && $stable(rdata),
    "stalled stage changed")
  `ASSERT_CLK(a_clear,
    take && s1_last |=> (check_accum == '0),
    "accumulator not cleared at frame end")

endmodule

`default_nettype wire
